/* sv/ssuid_pkg.sv */
// Shared constants, request and status codes, and controller/datapath interface types.
`default_nettype none

package ssuid_pkg;

    // Set sizing
    localparam int SET_CAPACITY = 16;
    localparam int VALUE_BITS   = 16;
    localparam int IDX_W        = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int CNT_W        = $clog2(SET_CAPACITY + 1);

    // Port field widths
    localparam int REQ_W  = 3;
    localparam int ELEM_W = 16;
    localparam int STAT_W = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INS_A = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_B = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UNION = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INTER = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DIFF  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic              load;       // request accepted: latch value, reset walk
        logic              sel_b;      // insert targets set B (valid with load)
        logic              inc_i;
        logic              inc_j;
        logic              dec_sel;    // step selected index down
        logic              save_pos;   // pos <= selected index
        logic              load_shift; // pos <= selected index, index <= count - 1
        logic              wr_shift;   // set[idx + 1] <= set[idx]
        logic              wr_ins;     // set[pos] <= value, count + 1
        logic              clr_sets;
        logic              produce;    // push a result into the hold stage
        logic              take_b;     // result comes from B
        logic              flush;      // emit held result as last, or empty marker
        logic              answer;     // emit single insert/clear answer
        logic [STAT_W-1:0] ans_status;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic             out_free;
        logic             i_end;
        logic             j_end;
        logic             a_lt_b;
        logic             b_lt_a;
        logic             a_eq_b;
        logic             sel_lt_v;
        logic             sel_eq_v;
        logic             sel_end;
        logic             sel_full;
        logic             at_pos;
        logic [CNT_W-1:0] cnt_a;
        logic [CNT_W-1:0] cnt_b;
    } t_sts;

endpackage

`default_nettype wire

/* sv/ssuid_datapath.sv */
// Datapath: set memories, counts, walk indices, result hold stage and output register.
`default_nettype none

module ssuid_datapath import ssuid_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [ELEM_W-1:0] i_value,
    output t_sts                   o_sts,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [ELEM_W-1:0]      o_out_elem,
    output logic [STAT_W-1:0]      o_out_status,
    output logic                   o_out_last
);

    // Set storage
    logic signed [VALUE_BITS-1:0] mem_a [SET_CAPACITY];
    logic signed [VALUE_BITS-1:0] mem_b [SET_CAPACITY];

    logic [CNT_W-1:0]             r_cnt_a, r_cnt_b;
    logic [CNT_W-1:0]             r_idx_i, r_idx_j, r_pos;
    logic signed [VALUE_BITS-1:0] r_rd_a, r_rd_b, r_val, r_pend;
    logic                         r_sel_b, r_pend_valid;
    logic                         r_out_valid, r_out_last;
    logic [ELEM_W-1:0]            r_out_elem;
    logic [STAT_W-1:0]            r_out_status;

    logic [CNT_W-1:0]             cur_idx, cur_cnt;
    logic signed [VALUE_BITS-1:0] cur_rd, cand;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic signed [VALUE_BITS-1:0] wr_data;
    logic                         emit;

    // Selected set for inserts
    assign cur_idx = r_sel_b ? r_idx_j : r_idx_i;
    assign cur_cnt = r_sel_b ? r_cnt_b : r_cnt_a;
    assign cur_rd  = r_sel_b ? r_rd_b  : r_rd_a;
    assign cand    = i_cmd.take_b ? r_rd_b : r_rd_a;

    // Write port: shift step or final insert
    always_comb begin
        wr_en   = i_cmd.wr_shift | i_cmd.wr_ins;
        wr_addr = i_cmd.wr_ins ? r_pos[IDX_W-1:0] : IDX_W'(cur_idx + 1'b1);
        wr_data = i_cmd.wr_ins ? r_val : cur_rd;
    end

    // Memories: one write, one registered read each
    always_ff @(posedge i_clk) begin
        if (wr_en && !r_sel_b) begin
            mem_a[wr_addr] <= wr_data;
        end
        r_rd_a <= mem_a[r_idx_i[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && r_sel_b) begin
            mem_b[wr_addr] <= wr_data;
        end
        r_rd_b <= mem_b[r_idx_j[IDX_W-1:0]];
    end

    // Counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_sets) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
        end else if (i_cmd.wr_ins) begin
            if (r_sel_b) begin
                r_cnt_b <= r_cnt_b + 1'b1;
            end else begin
                r_cnt_a <= r_cnt_a + 1'b1;
            end
        end
    end

    // Walk indices, insert position, latched request value
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx_i <= '0;
            r_idx_j <= '0;
            r_sel_b <= i_cmd.sel_b;
            r_val   <= VALUE_BITS'(i_value);
        end else begin
            if (i_cmd.inc_i) r_idx_i <= r_idx_i + 1'b1;
            if (i_cmd.inc_j) r_idx_j <= r_idx_j + 1'b1;
            if (i_cmd.dec_sel) begin
                if (r_sel_b) r_idx_j <= r_idx_j - 1'b1;
                else         r_idx_i <= r_idx_i - 1'b1;
            end
            if (i_cmd.load_shift) begin
                if (r_sel_b) r_idx_j <= CNT_W'(r_cnt_b - 1'b1);
                else         r_idx_i <= CNT_W'(r_cnt_a - 1'b1);
            end
        end
        if (i_cmd.save_pos || i_cmd.load_shift) begin
            r_pos <= cur_idx;
        end
    end

    // Hold stage: one result kept back so the last one can be marked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load || i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.produce) begin
            r_pend_valid <= 1'b1;
        end
        if (i_cmd.produce) begin
            r_pend <= cand;
        end
    end

    // Output register
    assign emit = i_cmd.answer | i_cmd.flush | (i_cmd.produce & r_pend_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.answer) begin
            r_out_elem   <= '0;
            r_out_status <= i_cmd.ans_status;
            r_out_last   <= 1'b1;
        end else if (i_cmd.flush) begin
            r_out_elem   <= r_pend_valid ? ELEM_W'(r_pend) : '0;
            r_out_status <= r_pend_valid ? ST_OK : ST_EMPTY;
            r_out_last   <= 1'b1;
        end else if (i_cmd.produce && r_pend_valid) begin
            r_out_elem   <= ELEM_W'(r_pend);
            r_out_status <= ST_OK;
            r_out_last   <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_elem   = r_out_elem;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

    // Status to controller
    always_comb begin
        o_sts.out_free = !r_out_valid || i_out_ready;
        o_sts.i_end    = r_idx_i >= r_cnt_a;
        o_sts.j_end    = r_idx_j >= r_cnt_b;
        o_sts.a_lt_b   = r_rd_a < r_rd_b;
        o_sts.b_lt_a   = r_rd_b < r_rd_a;
        o_sts.a_eq_b   = r_rd_a == r_rd_b;
        o_sts.sel_lt_v = cur_rd < r_val;
        o_sts.sel_eq_v = cur_rd == r_val;
        o_sts.sel_end  = cur_idx >= cur_cnt;
        o_sts.sel_full = cur_cnt >= CNT_W'(SET_CAPACITY);
        o_sts.at_pos   = cur_idx == r_pos;
        o_sts.cnt_a    = r_cnt_a;
        o_sts.cnt_b    = r_cnt_b;
    end

endmodule

`default_nettype wire

/* sv/ssuid_ctrl.sv */
// Controller: sequences insert search/shift, merge walks and clear.
`default_nettype none

module ssuid_ctrl import ssuid_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    input  wire logic [REQ_W-1:0] i_req_type,
    output logic                  o_req_ready,
    output t_cmd                  o_cmd,
    input  wire t_sts             i_sts
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH_F = 4'd1;
    localparam logic [3:0] S_SRCH_A = 4'd2;
    localparam logic [3:0] S_SHFT_F = 4'd3;
    localparam logic [3:0] S_SHFT_A = 4'd4;
    localparam logic [3:0] S_INS_WR = 4'd5;
    localparam logic [3:0] S_CLR    = 4'd6;
    localparam logic [3:0] S_MRG_F  = 4'd7;
    localparam logic [3:0] S_MRG_A  = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [REQ_W-1:0] r_req, n_req;
    logic             sel_b, match, keep;

    assign sel_b = (r_req == REQ_INS_B);
    assign match = !i_sts.j_end && i_sts.a_eq_b;
    assign keep  = (r_req == REQ_INTER) ? match : !match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= REQ_INS_A;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            // Accept a request and dispatch by kind
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_req       = i_req_type;
                    o_cmd.load  = 1'b1;
                    o_cmd.sel_b = (i_req_type == REQ_INS_B);
                    case (i_req_type) inside
                        REQ_INS_A, REQ_INS_B:           n_state = S_SRCH_F;
                        REQ_UNION, REQ_INTER, REQ_DIFF: n_state = S_MRG_F;
                        REQ_CLEAR:                      n_state = S_CLR;
                        default:                        n_state = S_IDLE;
                    endcase
                end
            end
            // Insert: linear search for the sorted position
            S_SRCH_F: n_state = S_SRCH_A;
            S_SRCH_A: begin
                if (i_sts.out_free) begin
                    if (!i_sts.sel_end && i_sts.sel_lt_v) begin
                        o_cmd.inc_i = !sel_b;
                        o_cmd.inc_j = sel_b;
                        n_state     = S_SRCH_F;
                    end else if (!i_sts.sel_end && i_sts.sel_eq_v) begin
                        o_cmd.answer     = 1'b1;
                        o_cmd.ans_status = ST_DUP;
                        n_state          = S_IDLE;
                    end else if (i_sts.sel_full) begin
                        o_cmd.answer     = 1'b1;
                        o_cmd.ans_status = ST_FULL;
                        n_state          = S_IDLE;
                    end else if (i_sts.sel_end) begin
                        o_cmd.save_pos = 1'b1;
                        n_state        = S_INS_WR;
                    end else begin
                        o_cmd.load_shift = 1'b1;
                        n_state          = S_SHFT_F;
                    end
                end
            end
            // Insert: move entries up one slot, top first
            S_SHFT_F: n_state = S_SHFT_A;
            S_SHFT_A: begin
                o_cmd.wr_shift = 1'b1;
                if (i_sts.at_pos) begin
                    n_state = S_INS_WR;
                end else begin
                    o_cmd.dec_sel = 1'b1;
                    n_state       = S_SHFT_F;
                end
            end
            S_INS_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.wr_ins     = 1'b1;
                    o_cmd.answer     = 1'b1;
                    o_cmd.ans_status = ST_OK;
                    n_state          = S_IDLE;
                end
            end
            S_CLR: begin
                if (i_sts.out_free) begin
                    o_cmd.clr_sets   = 1'b1;
                    o_cmd.answer     = 1'b1;
                    o_cmd.ans_status = ST_OK;
                    n_state          = S_IDLE;
                end
            end
            // Merge walk over both sets
            S_MRG_F: n_state = S_MRG_A;
            S_MRG_A: begin
                if (i_sts.out_free) begin
                    n_state = S_MRG_F;
                    if (r_req == REQ_UNION) begin
                        if (i_sts.i_end && i_sts.j_end) begin
                            o_cmd.flush = 1'b1;
                            n_state     = S_IDLE;
                        end else if (i_sts.j_end || (!i_sts.i_end && i_sts.a_lt_b)) begin
                            o_cmd.produce = 1'b1;
                            o_cmd.inc_i   = 1'b1;
                        end else if (i_sts.i_end || i_sts.b_lt_a) begin
                            o_cmd.produce = 1'b1;
                            o_cmd.take_b  = 1'b1;
                            o_cmd.inc_j   = 1'b1;
                        end else begin
                            o_cmd.produce = 1'b1;
                            o_cmd.inc_i   = 1'b1;
                            o_cmd.inc_j   = 1'b1;
                        end
                    end else begin
                        if (i_sts.i_end) begin
                            o_cmd.flush = 1'b1;
                            n_state     = S_IDLE;
                        end else if (!i_sts.j_end && i_sts.b_lt_a) begin
                            o_cmd.inc_j = 1'b1;
                        end else begin
                            o_cmd.produce = keep;
                            o_cmd.inc_i   = 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* sv/sorted_set_union_intersect_diff.sv */
// Top level: two sorted bounded sets with insert, union, intersect, difference and clear.
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request kind, tdata the
//   value to insert. Answers leave on the m_axis channel: tdata is the element, tuser
//   the status, tlast marks the final answer of a request.
//   Insert A/B returns one answer (ok, duplicate ignored or set full). Clear empties
//   both sets and returns one ok answer. Union, intersect and A minus B stream the
//   result set in ascending order; an empty result gives one answer flagged empty.
//   Unused request kinds return nothing.
//   One request is in work at a time; s_axis_tready is high only between requests.
//   Each memory has a registered read, so every search, shift or merge step is split
//   into a fetch state and an act state; a set operation takes up to the sum of both
//   counts in steps (32 results at most).
//   Answers sit in an output register; while one waits and m_axis_tready is low the walk
//   stalls, nothing is lost or repeated.
//   Synchronous active-low reset empties both sets and drops any pending answer;
//   stored values need no clearing since only entries below the counts are read.
`default_nettype none

module sorted_set_union_intersect_diff import ssuid_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [ELEM_W-1:0] s_axis_tdata,   // [15:0] value
    input  wire logic [REQ_W-1:0]  s_axis_tuser,   // [2:0] req_type
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [ELEM_W-1:0]      m_axis_tdata,   // [15:0] element
    output logic [STAT_W-1:0]      m_axis_tuser,   // [1:0] status
    output logic                   m_axis_tlast
);

    t_cmd cmd;
    t_sts sts;

    ssuid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_type  (s_axis_tuser),
        .o_req_ready (s_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ssuid_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (s_axis_tdata),
        .o_sts        (sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_elem   (m_axis_tdata),
        .o_out_status (m_axis_tuser),
        .o_out_last   (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // Counts never exceed capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sts.cnt_a <= CNT_W'(SET_CAPACITY)) && (sts.cnt_b <= CNT_W'(SET_CAPACITY)))
        else $error("set count above capacity");

    // An answer is only written when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.answer || cmd.flush || cmd.produce) |-> sts.out_free)
        else $error("answer written into a busy output register");

    // A count only drops through a clear
    a_cnt_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && ((sts.cnt_a < $past(sts.cnt_a)) || (sts.cnt_b < $past(sts.cnt_b))))
        |-> $past(cmd.clr_sets))
        else $error("set count dropped without clear");
`endif

endmodule

`default_nettype wire
